### sv/swd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types, codes and constants of the serial wire debug host engine.
// ----------------------------------------------------------------------------
package swd_pkg;

    localparam int unsigned SWITCH_SEQUENCE_DEF = 59294;
    localparam int unsigned IN_DEPTH_DEF        = 2;
    localparam int unsigned OUT_DEPTH_DEF       = 2;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_HIGH  = 1'd1;

    localparam logic [7:0] RETRY_LIMIT_RST = 8'd8;
    localparam logic [7:0] RESET_HIGH_RST  = 8'd150;

    localparam logic [2:0] ACK_OK   = 3'd1;
    localparam logic [2:0] ACK_HOLD = 3'd2;
    localparam logic [2:0] ACK_FAIL = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_PROTO  = 3'd3;
    localparam logic [2:0] ST_PARITY = 3'd4;

    localparam logic [7:0] LEN_REQ   = 8'd8;
    localparam logic [7:0] LEN_TRN   = 8'd1;
    localparam logic [7:0] LEN_ACK   = 8'd3;
    localparam logic [7:0] LEN_DATA  = 8'd33;
    localparam logic [7:0] LEN_IDLE8 = 8'd8;
    localparam logic [7:0] LEN_SW    = 8'd16;
    localparam logic [7:0] LEN_LRIDL = 8'd16;
    localparam logic [7:0] WORD_BITS = 8'd32;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_LRESET = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_REQ    = 4'd1,
        PH_TRN1   = 4'd2,
        PH_ACK    = 4'd3,
        PH_RDATA  = 4'd4,
        PH_TRN2   = 4'd5,
        PH_WDATA  = 4'd6,
        PH_IDLE8  = 4'd7,
        PH_LRH1   = 4'd8,
        PH_LRSW   = 4'd9,
        PH_LRH2   = 4'd10,
        PH_LRIDLE = 4'd11
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        ap_sel;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
        logic        ignore_ack;
        logic        line_in;
    } item_t;

    typedef struct packed {
        logic        drive_bit;
        logic        drive_enable;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] read_data;
    } result_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

endpackage
`default_nettype wire

### sv/swd_host_transaction_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_host_transaction_engine
// Serial wire debug host: one queued item per wire cycle, one result each.
// ----------------------------------------------------------------------------
// a result passes the input queue register, then the combinational sequencer step into
//   the result queue register; a full result queue holds the item in the input queue
// throughput: one item per clock while the result queue is not full, set by the sequencer step
// reset: asynchronous, clears both queues and the sequencer to idle;
//   retry_limit returns to 8 and reset_high_cycles to 150
module swd_host_transaction_engine #(
    parameter int unsigned IN_DEPTH        = swd_pkg::IN_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH       = swd_pkg::OUT_DEPTH_DEF,
    parameter logic [15:0] SWITCH_SEQUENCE = 16'(swd_pkg::SWITCH_SEQUENCE_DEF)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [1:0]                        mode,
    input  wire logic                              ap_sel,
    input  wire logic [1:0]                        reg_addr,
    input  wire logic [31:0]                       write_data,
    input  wire logic                              ignore_ack,
    input  wire logic                              line_in,
    input  wire logic                              cfg_we,
    input  wire logic [swd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [swd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   drive_bit,
    output logic                                   drive_enable,
    output logic                                   busy_res,
    output logic                                   done_res,
    output logic [2:0]                             status,
    output logic [31:0]                            read_data
);
    import swd_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t res_in;
    result_t res_out;
    logic    res_push;
    logic    res_full;
    cfg_wr_t cfg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    swd_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .ap_sel     (ap_sel),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .ignore_ack (ignore_ack),
        .line_in    (line_in),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    swd_engine #(
        .SWITCH_SEQUENCE (SWITCH_SEQUENCE)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    // result queue parts the sequencer from the consumer
    swd_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign drive_bit    = res_out.drive_bit;
    assign drive_enable = res_out.drive_enable;
    assign busy_res     = res_out.busy_res;
    assign done_res     = res_out.done_res;
    assign status       = res_out.status;
    assign read_data    = res_out.read_data;

endmodule
`default_nettype wire

### sv/swd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_queue
// Small first-in first-out register queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module swd_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### sv/swd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_front
// Accepts wire-cycle items, classifies the mode code and queues them.
// ----------------------------------------------------------------------------
module swd_front #(
    parameter int unsigned DEPTH = swd_pkg::IN_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [1:0]    mode,
    input  wire logic          ap_sel,
    input  wire logic [1:0]    reg_addr,
    input  wire logic [31:0]   write_data,
    input  wire logic          ignore_ack,
    input  wire logic          line_in,
    output logic               item_valid,
    input  wire logic          item_take,
    output swd_pkg::item_t     item
);
    import swd_pkg::*;

    item_t item_in;
    logic  q_empty;

    always_comb
    begin
        case (kind_t'(mode))
            KIND_READ:   item_in.kind = KIND_READ;
            KIND_WRITE:  item_in.kind = KIND_WRITE;
            KIND_LRESET: item_in.kind = KIND_LRESET;
            default:     item_in.kind = KIND_TICK;
        endcase
        item_in.ap_sel     = ap_sel;
        item_in.reg_addr   = reg_addr;
        item_in.write_data = write_data;
        item_in.ignore_ack = ignore_ack;
        item_in.line_in    = line_in;
    end

    swd_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (DEPTH)
    ) u_in_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item_in),
        .full      (full),
        .pop       (item_take),
        .pop_data  (item),
        .empty     (q_empty)
    );

    assign item_valid = !q_empty;

endmodule
`default_nettype wire

### sv/swd_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_engine
// Protocol sequencer: one wire cycle per queued item, one result per item.
// ----------------------------------------------------------------------------
module swd_engine #(
    parameter logic [15:0] SWITCH_SEQUENCE = 16'(swd_pkg::SWITCH_SEQUENCE_DEF)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire swd_pkg::cfg_wr_t  cfg,
    input  wire logic              item_valid,
    output logic                   item_take,
    input  wire swd_pkg::item_t    item,
    input  wire logic              res_full,
    output logic                   res_push,
    output swd_pkg::result_t       res
);
    import swd_pkg::*;

    logic [7:0]  retry_limit_reg;
    logic [7:0]  reset_high_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  bc_reg, bc_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  ack_reg, ack_next;
    logic        par_reg, par_next;
    logic [7:0]  att_reg, att_next;
    logic        is_read_reg, is_read_next;
    logic        ap_reg, ap_next;
    logic [1:0]  reg_sel_reg, reg_sel_next;
    logic [31:0] data_reg, data_next;
    logic        ignore_reg, ignore_next;

    phase_t      cur_phase;
    logic [7:0]  cur_bc;
    logic [7:0]  len;
    logic [7:0]  nx;
    logic        pend;
    logic [7:0]  req;
    logic        fire;
    logic        sent;

    assign fire      = item_valid && !res_full;
    assign item_take = fire;
    assign res_push  = fire;

    always_comb
    begin
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        shift_next   = shift_reg;
        ack_next     = ack_reg;
        par_next     = par_reg;
        att_next     = att_reg;
        is_read_next = is_read_reg;
        ap_next      = ap_reg;
        reg_sel_next = reg_sel_reg;
        data_next    = data_reg;
        ignore_next  = ignore_reg;
        cur_phase    = phase_reg;
        cur_bc       = bc_reg;

        res              = '0;
        res.drive_enable = 1'b1;

        // a start is taken only from idle; it also counts as the first cycle
        if (phase_reg == PH_IDLE && item.kind != KIND_TICK)
        begin
            ap_next      = item.ap_sel;
            reg_sel_next = item.reg_addr;
            data_next    = item.write_data;
            ignore_next  = item.ignore_ack;
            is_read_next = (item.kind == KIND_READ);
            cur_bc       = '0;
            if (item.kind == KIND_LRESET)
            begin
                cur_phase = PH_LRH1;
            end
            else
            begin
                cur_phase  = PH_REQ;
                att_next   = retry_limit_reg;
                shift_next = '0;
                ack_next   = '0;
                par_next   = 1'b0;
            end
        end
        phase_next = cur_phase;

        case (cur_phase)
            PH_REQ:    len = LEN_REQ;
            PH_TRN1:   len = LEN_TRN;
            PH_ACK:    len = LEN_ACK;
            PH_RDATA:  len = LEN_DATA;
            PH_TRN2:   len = LEN_TRN;
            PH_WDATA:  len = LEN_DATA;
            PH_IDLE8:  len = LEN_IDLE8;
            PH_LRH1:   len = reset_high_reg;
            PH_LRSW:   len = LEN_SW;
            PH_LRH2:   len = reset_high_reg;
            PH_LRIDLE: len = LEN_LRIDL;
            default:   len = LEN_TRN;
        endcase
        nx   = cur_bc + 8'd1;
        pend = (nx == len);

        req  = {1'b1, 1'b0, ap_next ^ is_read_next ^ reg_sel_next[0] ^ reg_sel_next[1],
                reg_sel_next[1], reg_sel_next[0], is_read_next, ap_next, 1'b1};
        sent = (ack_next == ACK_OK) || (!is_read_next && ignore_next);

        if (cur_phase != PH_IDLE)
        begin
            res.busy_res = 1'b1;
            bc_next      = pend ? 8'd0 : nx;
        end

        case (cur_phase)
            PH_IDLE:
            begin
                res.busy_res = 1'b0;
            end
            PH_REQ:
            begin
                res.drive_bit = req[cur_bc[2:0]];
                if (pend)
                begin
                    phase_next = PH_TRN1;
                end
            end
            PH_TRN1:
            begin
                res.drive_enable = 1'b0;
                if (pend)
                begin
                    phase_next = PH_ACK;
                end
            end
            PH_ACK:
            begin
                res.drive_enable = 1'b0;
                ack_next = ack_reg | (3'(item.line_in) << cur_bc[1:0]);
                if (pend)
                begin
                    phase_next = (is_read_next && ack_next == ACK_OK) ? PH_RDATA : PH_TRN2;
                end
            end
            PH_RDATA:
            begin
                res.drive_enable = 1'b0;
                if (cur_bc < WORD_BITS)
                begin
                    shift_next = shift_reg | (32'(item.line_in) << cur_bc[4:0]);
                end
                par_next = par_reg ^ item.line_in;
                if (pend)
                begin
                    phase_next = PH_TRN2;
                end
            end
            PH_TRN2:
            begin
                res.drive_enable = 1'b0;
                if (pend)
                begin
                    phase_next = (!is_read_next && sent) ? PH_WDATA : PH_IDLE8;
                end
            end
            PH_WDATA:
            begin
                res.drive_bit = (cur_bc < WORD_BITS) ? data_next[cur_bc[4:0]] : ^data_next;
                if (pend)
                begin
                    phase_next = PH_IDLE8;
                end
            end
            PH_IDLE8:
            begin
                if (pend)
                begin
                    phase_next = PH_IDLE;
                    if (!sent && ack_next == ACK_HOLD && att_reg != 8'd1)
                    begin
                        // target still busy: run the whole transaction again
                        att_next   = att_reg - 8'd1;
                        phase_next = PH_REQ;
                        shift_next = '0;
                        ack_next   = '0;
                        par_next   = 1'b0;
                    end
                    else
                    begin
                        res.done_res  = 1'b1;
                        res.read_data = is_read_next ? shift_next : 32'd0;
                        if (!sent && ack_next == ACK_HOLD)
                        begin
                            att_next   = att_reg - 8'd1;
                            res.status = ST_WAIT;
                        end
                        else if (sent)
                        begin
                            res.status = (is_read_next && par_next) ? ST_PARITY : ST_OK;
                        end
                        else if (ack_next == ACK_FAIL)
                        begin
                            res.status = ST_FAULT;
                        end
                        else
                        begin
                            res.status = ST_PROTO;
                        end
                    end
                end
            end
            PH_LRH1:
            begin
                res.drive_bit = 1'b1;
                if (pend)
                begin
                    phase_next = PH_LRSW;
                end
            end
            PH_LRSW:
            begin
                res.drive_bit = SWITCH_SEQUENCE[cur_bc[3:0]];
                if (pend)
                begin
                    phase_next = PH_LRH2;
                end
            end
            PH_LRH2:
            begin
                res.drive_bit = 1'b1;
                if (pend)
                begin
                    phase_next = PH_LRIDLE;
                end
            end
            PH_LRIDLE:
            begin
                if (pend)
                begin
                    res.done_res = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                bc_next      = '0;
                res.done_res = 1'b1;
                res.status   = ST_PROTO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            reset_high_reg  <= RESET_HIGH_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg.data;
                CFG_RESET_HIGH:  reset_high_reg  <= cfg.data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bc_reg      <= '0;
            shift_reg   <= '0;
            ack_reg     <= '0;
            par_reg     <= 1'b0;
            att_reg     <= '0;
            is_read_reg <= 1'b0;
            ap_reg      <= 1'b0;
            reg_sel_reg <= '0;
            data_reg    <= '0;
            ignore_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            shift_reg   <= shift_next;
            ack_reg     <= ack_next;
            par_reg     <= par_next;
            att_reg     <= att_next;
            is_read_reg <= is_read_next;
            ap_reg      <= ap_next;
            reg_sel_reg <= reg_sel_next;
            data_reg    <= data_next;
            ignore_reg  <= ignore_next;
        end
    end

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial wire debug host engine. A cycle-level
// predictor of the wire sequencer runs on every accepted item; each popped
// result is compared field by field with the oldest prediction. Stimulus is
// planned transactions (acks, retries, data, parity) plus line resets,
// noise and several fixed settings of both registers.
// ----------------------------------------------------------------------------
module tb;
    import swd_pkg::*;

    localparam int          LATENCY     = 4;
    localparam int          HOLD_CYCLES = 400;
    localparam int          SEG_ITEMS   = 100;
    localparam logic [15:0] SWITCH_BITS = 16'(SWITCH_SEQUENCE_DEF);
    localparam logic [2:0]  ACK_NONE    = 3'd0;
    localparam logic [2:0]  ACK_JUNK    = 3'd7;

    // cycle offsets within one attempt on the wire
    localparam int ACK_AT    = LEN_REQ + LEN_TRN;
    localparam int DATA_AT   = ACK_AT + LEN_ACK;
    localparam int SHORT_LEN = LEN_REQ + 2 * LEN_TRN + LEN_ACK + LEN_IDLE8;
    localparam int FULL_LEN  = SHORT_LEN + LEN_DATA;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [1:0] mode = '0;
    logic ap_sel = 1'b0;
    logic [1:0] reg_addr = '0;
    logic [31:0] write_data = '0;
    logic ignore_ack = 1'b0;
    logic line_in = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic empty;
    logic pop = 1'b0;
    logic drive_bit;
    logic drive_enable;
    logic busy_res;
    logic done_res;
    logic [2:0] status;
    logic [31:0] read_data;

    swd_host_transaction_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .ap_sel       (ap_sel),
        .reg_addr     (reg_addr),
        .write_data   (write_data),
        .ignore_ack   (ignore_ack),
        .line_in      (line_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .empty        (empty),
        .pop          (pop),
        .drive_bit    (drive_bit),
        .drive_enable (drive_enable),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .read_data    (read_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    item_t   wire_plan[$];
    result_t cycles_due[$];
    item_t   offer;
    int      n_planned = 0;
    int      n_checked = 0;
    int      n_errs = 0;
    int      tx_idle_pct = 23;
    int      rx_idle_pct = 62;
    logic    rx_hold = 1'b0;
    logic    hold_arm = 1'b0;

    // predictor copy of the registers and the wire sequencer
    logic [7:0]  retry_lim = RETRY_LIMIT_RST;
    logic [7:0]  high_len = RESET_HIGH_RST;
    phase_t      eng_phase = PH_IDLE;
    logic [7:0]  eng_cnt = '0;
    logic [31:0] eng_word = '0;
    logic [2:0]  eng_ack = '0;
    logic        eng_par = 1'b0;
    logic [7:0]  eng_tries = '0;
    logic        eng_rd = 1'b0;
    logic        eng_ap = 1'b0;
    logic [1:0]  eng_reg = '0;
    logic [31:0] eng_data = '0;
    logic        eng_ign = 1'b0;

    // one step of a phase of length len (0 wraps the full 8-bit count), true at its end
    function automatic logic count_phase(input logic [7:0] len);
        logic [7:0] nx;
        nx = eng_cnt + 8'd1;
        if (nx == len)
        begin
            eng_cnt = '0;
            return 1'b1;
        end
        eng_cnt = nx;
        return 1'b0;
    endfunction

    function automatic logic data_goes();
        return eng_ack == ACK_OK || (!eng_rd && eng_ign);
    endfunction

    function automatic void new_attempt();
        eng_phase = PH_REQ;
        eng_cnt = '0;
        eng_word = '0;
        eng_ack = '0;
        eng_par = 1'b0;
    endfunction

    function automatic result_t wire_cycle(input item_t it);
        result_t r;
        logic [7:0] req;
        r = '0;
        r.drive_enable = 1'b1;
        if (eng_phase == PH_IDLE)
        begin
            if (it.kind == KIND_TICK)
                return r;
            eng_ap = it.ap_sel;
            eng_reg = it.reg_addr;
            eng_data = it.write_data;
            eng_ign = it.ignore_ack;
            eng_rd = (it.kind == KIND_READ);
            if (it.kind == KIND_LRESET)
            begin
                eng_phase = PH_LRH1;
                eng_cnt = '0;
            end
            else
            begin
                eng_tries = retry_lim;
                new_attempt();
            end
        end
        r.busy_res = 1'b1;
        case (eng_phase)
            PH_REQ:
            begin
                req = {1'b1, 1'b0, eng_ap ^ eng_rd ^ eng_reg[0] ^ eng_reg[1],
                       eng_reg[1], eng_reg[0], eng_rd, eng_ap, 1'b1};
                r.drive_bit = req[eng_cnt[2:0]];
                if (count_phase(LEN_REQ))
                    eng_phase = PH_TRN1;
            end
            PH_TRN1:
            begin
                r.drive_enable = 1'b0;
                if (count_phase(LEN_TRN))
                    eng_phase = PH_ACK;
            end
            PH_ACK:
            begin
                r.drive_enable = 1'b0;
                eng_ack = eng_ack | (3'(it.line_in) << eng_cnt[1:0]);
                if (count_phase(LEN_ACK))
                    eng_phase = (eng_rd && eng_ack == ACK_OK) ? PH_RDATA : PH_TRN2;
            end
            PH_RDATA:
            begin
                r.drive_enable = 1'b0;
                if (eng_cnt < WORD_BITS)
                    eng_word[eng_cnt[4:0]] = it.line_in;
                eng_par = eng_par ^ it.line_in;
                if (count_phase(LEN_DATA))
                    eng_phase = PH_TRN2;
            end
            PH_TRN2:
            begin
                r.drive_enable = 1'b0;
                if (count_phase(LEN_TRN))
                    eng_phase = (!eng_rd && data_goes()) ? PH_WDATA : PH_IDLE8;
            end
            PH_WDATA:
            begin
                r.drive_bit = (eng_cnt < WORD_BITS) ? eng_data[eng_cnt[4:0]] : ^eng_data;
                if (count_phase(LEN_DATA))
                    eng_phase = PH_IDLE8;
            end
            PH_IDLE8:
            begin
                if (count_phase(LEN_IDLE8))
                begin
                    if (!data_goes() && eng_ack == ACK_HOLD)
                    begin
                        eng_tries = eng_tries - 8'd1;
                        if (eng_tries != 0)
                        begin
                            new_attempt();
                            return r;
                        end
                        r.status = ST_WAIT;
                    end
                    else if (data_goes())
                        r.status = (eng_rd && eng_par) ? ST_PARITY : ST_OK;
                    else if (eng_ack == ACK_FAIL)
                        r.status = ST_FAULT;
                    else
                        r.status = ST_PROTO;
                    r.done_res = 1'b1;
                    r.read_data = eng_rd ? eng_word : '0;
                    eng_phase = PH_IDLE;
                end
            end
            PH_LRH1:
            begin
                r.drive_bit = 1'b1;
                if (count_phase(high_len))
                    eng_phase = PH_LRSW;
            end
            PH_LRSW:
            begin
                r.drive_bit = SWITCH_BITS[eng_cnt[3:0]];
                if (count_phase(LEN_SW))
                    eng_phase = PH_LRH2;
            end
            PH_LRH2:
            begin
                r.drive_bit = 1'b1;
                if (count_phase(high_len))
                    eng_phase = PH_LRIDLE;
            end
            PH_LRIDLE:
            begin
                if (count_phase(LEN_LRIDL))
                begin
                    r.done_res = 1'b1;
                    eng_phase = PH_IDLE;
                end
            end
            default:
            begin
                eng_phase = PH_IDLE;
                eng_cnt = '0;
                r.done_res = 1'b1;
                r.status = ST_PROTO;
            end
        endcase
        return r;
    endfunction

    // driver: offers planned items, holds an offer until the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                cycles_due.push_back(wire_cycle(offer));
            if (push && full)
            begin
                // offer stays on the ports
            end
            else if (wire_plan.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                offer = wire_plan.pop_front();
                push <= 1'b1;
                mode <= offer.kind;
                ap_sel <= offer.ap_sel;
                reg_addr <= offer.reg_addr;
                write_data <= offer.write_data;
                ignore_ack <= offer.ignore_ack;
                line_in <= offer.line_in;
            end
            else
                push <= 1'b0;
        end
    end

    // monitor: checks every result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (cycles_due.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    n_errs++;
                end
                else
                begin
                    want = cycles_due.pop_front();
                    n_checked++;
                    if (drive_bit !== want.drive_bit)
                    begin
                        $error("drive_bit: expected %0d, got %0d", want.drive_bit, drive_bit);
                        n_errs++;
                    end
                    if (drive_enable !== want.drive_enable)
                    begin
                        $error("drive_enable: expected %0d, got %0d",
                               want.drive_enable, drive_enable);
                        n_errs++;
                    end
                    if (busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy_res, busy_res);
                        n_errs++;
                    end
                    if (done_res !== want.done_res)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done_res, done_res);
                        n_errs++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        n_errs++;
                    end
                    if (read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, read_data);
                        n_errs++;
                    end
                end
            end
            pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off so the engine backs up and raises full
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void queue_item(input item_t it);
        wire_plan.push_back(it);
        n_planned++;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.kind = kind_t'($urandom_range(3));
        it.ap_sel = $urandom_range(1);
        it.reg_addr = $urandom_range(3);
        it.write_data = $urandom;
        it.ignore_ack = $urandom_range(1);
        it.line_in = $urandom_range(1);
        return it;
    endfunction

    function automatic void queue_ticks(input int n);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it = noise_item();
            it.kind = KIND_TICK;
            queue_item(it);
        end
    endfunction

    function automatic logic [2:0] bad_ack();
        logic [2:0] a;
        do
            a = 3'($urandom_range(7));
        while (a == ACK_OK || a == ACK_HOLD || a == ACK_FAIL);
        return a;
    endfunction

    // plans one read or write: waits WAIT acks (none for a write that ignores acks), then
    // last_ack unless the attempts run out; word is the write data or the word the target sends
    function automatic void queue_xfer(input kind_t k, input logic ign, input int waits,
                                       input logic [2:0] last_ack, input logic [31:0] word,
                                       input logic bad_par);
        int allowed;
        int n_try;
        int len;
        logic [2:0] a;
        logic sends;
        item_t it;
        allowed = (retry_lim == 0) ? 256 : retry_lim;
        if (k == KIND_WRITE && ign)
            waits = 0;
        n_try = (waits >= allowed) ? allowed : waits + 1;
        for (int t = 0; t < n_try; t++)
        begin
            a = (t < waits) ? ACK_HOLD : last_ack;
            sends = (a == ACK_OK) || (k == KIND_WRITE && ign);
            len = sends ? FULL_LEN : SHORT_LEN;
            for (int c = 0; c < len; c++)
            begin
                it = noise_item();
                if (t == 0 && c == 0)
                begin
                    it.kind = k;
                    it.ignore_ack = ign;
                    it.write_data = word;
                end
                if (c >= ACK_AT && c < DATA_AT)
                    it.line_in = a[c - ACK_AT];
                else if (k == KIND_READ && sends && c >= DATA_AT && c < DATA_AT + 32)
                    it.line_in = word[c - DATA_AT];
                else if (k == KIND_READ && sends && c == DATA_AT + 32)
                    it.line_in = ^word ^ bad_par;
                queue_item(it);
            end
        end
    endfunction

    function automatic void queue_lreset();
        item_t it;
        int hi;
        hi = (high_len == 0) ? 256 : high_len;
        it = noise_item();
        it.kind = KIND_LRESET;
        queue_item(it);
        repeat (2 * hi + 2 * LEN_SW - 1) queue_item(noise_item());
    endfunction

    task automatic wait_drained();
        wait (n_checked == n_planned);
        @(negedge clk);
    endtask

    // ticks until the sequencer is back to idle
    task automatic finish_op();
        wait_drained();
        while (eng_phase != PH_IDLE)
        begin
            queue_ticks(16);
            wait_drained();
        end
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_RETRY_LIMIT)
            retry_lim = val;
        else
            high_len = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_ops(input int budget);
        int first;
        int sel;
        int pick;
        kind_t k;
        logic ign;
        logic [2:0] a;
        first = n_planned;
        while (n_planned - first < budget)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
            begin
                k = (sel < 40) ? KIND_READ : KIND_WRITE;
                ign = (k == KIND_WRITE) && ($urandom_range(2) == 0);
                pick = $urandom_range(99);
                if (pick < 65)
                    a = ACK_OK;
                else if (pick < 82)
                    a = ACK_FAIL;
                else
                    a = bad_ack();
                queue_xfer(k, ign, ($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0,
                           a, $urandom, $urandom_range(4) == 0);
            end
            else if (sel < 88)
                queue_lreset();
            else
            begin
                // broken traffic: random starts and line values
                repeat ($urandom_range(1, 12)) queue_item(noise_item());
                finish_op();
            end
            queue_ticks($urandom_range(0, 3));
        end
    endtask

    initial
    begin
        item_t it;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_ticks(3);
        queue_xfer(KIND_READ, 1'b0, 0, ACK_OK, 32'h0000_0000, 1'b0);
        queue_xfer(KIND_READ, 1'b0, 0, ACK_OK, 32'hFFFF_FFFF, 1'b1);
        queue_xfer(KIND_WRITE, 1'b0, 0, ACK_OK, 32'hFFFF_FFFF, 1'b0);
        queue_xfer(KIND_WRITE, 1'b0, 0, ACK_OK, 32'h0000_0000, 1'b0);
        queue_xfer(KIND_WRITE, 1'b1, 0, ACK_FAIL, $urandom, 1'b0);
        queue_xfer(KIND_WRITE, 1'b1, 0, ACK_HOLD, $urandom, 1'b0);
        queue_xfer(KIND_READ, 1'b0, 0, ACK_FAIL, $urandom, 1'b0);
        queue_xfer(KIND_READ, 1'b0, 0, ACK_JUNK, $urandom, 1'b0);
        queue_xfer(KIND_WRITE, 1'b0, 0, ACK_NONE, $urandom, 1'b0);
        queue_xfer(KIND_WRITE, 1'b0, 0, ACK_FAIL, $urandom, 1'b0);
        queue_xfer(KIND_READ, 1'b0, 2, ACK_OK, $urandom, 1'b0);
        queue_ticks(2);

        set_reg(CFG_RETRY_LIMIT, 8'd1);
        queue_xfer(KIND_READ, 1'b0, 1, ACK_OK, $urandom, 1'b0);
        queue_xfer(KIND_WRITE, 1'b0, 3, ACK_OK, $urandom, 1'b0);
        // zero limit means 256 attempts
        set_reg(CFG_RETRY_LIMIT, 8'd0);
        queue_xfer(KIND_READ, 1'b0, 3, ACK_OK, $urandom, 1'b0);
        set_reg(CFG_RETRY_LIMIT, 8'd255);
        queue_xfer(KIND_WRITE, 1'b0, 4, ACK_OK, $urandom, 1'b0);

        // lengthen the high phase while it runs
        set_reg(CFG_RESET_HIGH, 8'd50);
        it = noise_item();
        it.kind = KIND_LRESET;
        queue_item(it);
        repeat (20) queue_item(noise_item());
        set_reg(CFG_RESET_HIGH, 8'd60);
        finish_op();

        set_reg(CFG_RETRY_LIMIT, 8'd1);
        set_reg(CFG_RESET_HIGH, 8'd50);
        random_ops(SEG_ITEMS);

        finish_op();
        set_reg(CFG_RETRY_LIMIT, 8'd3);
        set_reg(CFG_RESET_HIGH, 8'd52);
        tx_idle_pct <= 62;
        rx_idle_pct <= 23;
        random_ops(SEG_ITEMS);

        finish_op();
        set_reg(CFG_RETRY_LIMIT, 8'd2);
        set_reg(CFG_RESET_HIGH, 8'd51);
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        hold_arm = 1'b1;
        random_ops(SEG_ITEMS);

        wait_drained();
        repeat (8) @(posedge clk);
        if (n_errs == 0 && cycles_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
